[rtl/fixed_width_word_wrap_assert.svh]
// Assertion macros shared by the word wrap RTL.
// Included by the modules that check their own queue and back-end logic.
`ifndef FIXED_WIDTH_WORD_WRAP_ASSERT_SVH
`define FIXED_WIDTH_WORD_WRAP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define FWW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define FWW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FWW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FWW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/fww_pkg.sv]
// Types and constants for the fixed-width word wrap block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fww_pkg;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Lines one character can close at most
    localparam int MAX_RESULTS = 3;
    // Entries in the queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CHARS_PER_LINE = 3'd0,
        REG_CHAR_WIDTH     = 3'd1,
        REG_CHAR_HEIGHT    = 3'd2,
        REG_BOX_X          = 3'd3,
        REG_BOX_Y          = 3'd4,
        REG_BOX_WIDTH      = 3'd5,
        REG_ALIGN_MODE     = 3'd6
    } t_reg_idx;

    // Horizontal alignment codes
    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_CENTER = 2'd1,
        ALIGN_RIGHT  = 2'd2
    } t_align;

    // Configuration register file
    typedef struct packed {
        logic [7:0]  chars_per_line;
        logic [7:0]  char_width;
        logic [7:0]  char_height;
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [15:0] box_width;
        logic [1:0]  align_mode;
    } t_cfg;

    // One closed line before alignment
    typedef struct packed {
        logic [15:0] start;
        logic [7:0]  len;
        logic [15:0] y;
        logic        last;
    } t_line_rec;

    // Lines closed by one character, slot 0 first
    typedef struct packed {
        t_line_rec [MAX_RESULTS-1:0] rec;
        logic [1:0]                  cnt;
    } t_group;

    // Group word with its valid flag
    typedef struct packed {
        logic   valid;
        t_group grp;
    } t_group_msg;

endpackage

[rtl/fww_front.sv]
// Front end: tracks words and line state per character, closes lines.
// Depends on fww_pkg; feeds line groups into fww_queue.
`timescale 1ns / 1ps

module fww_front #(
    parameter int OFFSET_BITS = 16,
    parameter int LIM_CAP     = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    input  fww_pkg::t_cfg      i_cfg,
    input  logic               i_box_y_load,
    input  logic [15:0]        i_box_y_data,
    output fww_pkg::t_group_msg o_push
);
    import fww_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam logic [OB-1:0] ONE  = OB'(1);
    localparam logic [OB-1:0] TWO  = OB'(2);
    localparam logic [7:0]    CAP8 = LIM_CAP[7:0];

    // Line state
    logic [OB-1:0] r_pos, r_cls, r_wb;
    logic [7:0]    r_acc;
    logic          r_hw, r_skip, r_acr;
    logic [15:0]   r_y;

    logic [OB-1:0] n_pos, n_cls, n_wb;
    logic [7:0]    n_acc;
    logic          n_hw, n_skip, n_acr;
    logic [15:0]   n_y;
    t_group        n_grp;

    logic [7:0]    lim;
    logic [OB-1:0] lim_ext;
    logic [15:0]   y_at [0:MAX_RESULTS];

    // Usable width and the y of each possible line of this character
    always_comb begin
        lim     = (i_cfg.chars_per_line > CAP8) ? CAP8 : i_cfg.chars_per_line;
        lim_ext = OB'(lim);
        y_at[0] = r_y;
        y_at[1] = r_y + {8'd0, i_cfg.char_height};
        y_at[2] = r_y + {7'd0, i_cfg.char_height, 1'b0};
        y_at[3] = y_at[1] + {7'd0, i_cfg.char_height, 1'b0};
    end

    // Classify the character and close lines
    always_comb begin
        logic [OB-1:0] p, q, span, len_w;
        logic          done;
        p      = r_pos;
        q      = r_pos + ONE;
        span   = '0;
        len_w  = '0;
        done   = 1'b0;
        n_cls  = r_cls;
        n_wb   = r_wb;
        n_acc  = r_acc;
        n_hw   = r_hw;
        n_skip = r_skip;
        n_acr  = 1'b0;
        n_grp  = '0;

        if (lim == 8'd0 || (r_acr && i_char_code == CH_LF)) begin
            // drop: zero width or LF of a CR-LF pair
            done = 1'b1;
        end else if (i_char_code == CH_LF || i_char_code == CH_CR) begin
            // close the line at a break
            n_grp.rec[n_grp.cnt].start = 16'(r_cls);
            if (r_skip && !r_hw) begin
                n_grp.rec[n_grp.cnt].start = 16'(p);
                n_grp.rec[n_grp.cnt].len   = 8'd0;
            end else if (r_skip) begin
                n_grp.rec[n_grp.cnt].len = r_acc;
            end else begin
                len_w = ((p - r_wb) != '0) ? (p - r_cls) : OB'(r_acc);
                n_grp.rec[n_grp.cnt].len = len_w[7:0];
            end
            n_grp.rec[n_grp.cnt].y    = y_at[n_grp.cnt];
            n_grp.rec[n_grp.cnt].last = i_last_char;
            n_grp.cnt = n_grp.cnt + 2'd1;
            n_skip = 1'b1;
            n_hw   = 1'b0;
            n_acc  = 8'd0;
            n_acr  = (i_char_code == CH_CR);
            done   = 1'b1;
        end else if (i_char_code == CH_SPACE) begin
            // end a word, stop taking words once the next cannot fit
            if (!r_skip) begin
                if ((p - r_wb) != '0) begin
                    len_w = p - r_cls;
                    n_acc = len_w[7:0];
                    n_hw  = 1'b1;
                end
                n_wb = q;
                if (n_hw && (p + TWO - r_cls) > lim_ext) begin
                    n_skip = 1'b1;
                end
            end
        end else if (r_skip) begin
            // first word character after spaces: flush the held line
            if (r_hw) begin
                n_grp.rec[n_grp.cnt].start = 16'(r_cls);
                n_grp.rec[n_grp.cnt].len   = r_acc;
                n_grp.rec[n_grp.cnt].y     = y_at[n_grp.cnt];
                n_grp.rec[n_grp.cnt].last  = 1'b0;
                n_grp.cnt = n_grp.cnt + 2'd1;
            end
            n_cls  = p;
            n_wb   = p;
            n_acc  = 8'd0;
            n_hw   = 1'b0;
            n_skip = 1'b0;
        end else begin
            // word character: wrap before the word, or chunk a long word
            span = q - r_cls;
            if (span > lim_ext && r_hw) begin
                n_grp.rec[n_grp.cnt].start = 16'(r_cls);
                n_grp.rec[n_grp.cnt].len   = r_acc;
                n_grp.rec[n_grp.cnt].y     = y_at[n_grp.cnt];
                n_grp.rec[n_grp.cnt].last  = 1'b0;
                n_grp.cnt = n_grp.cnt + 2'd1;
                n_cls = r_wb;
                n_hw  = 1'b0;
                n_acc = 8'd0;
                span  = q - n_cls;
            end
            if (span > lim_ext) begin
                n_grp.rec[n_grp.cnt].start = 16'(n_cls);
                n_grp.rec[n_grp.cnt].len   = lim;
                n_grp.rec[n_grp.cnt].y     = y_at[n_grp.cnt];
                n_grp.rec[n_grp.cnt].last  = 1'b0;
                n_grp.cnt = n_grp.cnt + 2'd1;
                n_cls = n_cls + lim_ext;
                n_wb  = n_cls;
            end
        end

        // close the open line at the end of the text
        if (!done && i_last_char) begin
            if (!n_skip) begin
                len_w = ((q - n_wb) != '0) ? (q - n_cls) : OB'(n_acc);
                n_grp.rec[n_grp.cnt].start = 16'(n_cls);
                n_grp.rec[n_grp.cnt].len   = len_w[7:0];
                n_grp.rec[n_grp.cnt].y     = y_at[n_grp.cnt];
                n_grp.rec[n_grp.cnt].last  = 1'b1;
                n_grp.cnt = n_grp.cnt + 2'd1;
            end else if (n_hw) begin
                n_grp.rec[n_grp.cnt].start = 16'(n_cls);
                n_grp.rec[n_grp.cnt].len   = n_acc;
                n_grp.rec[n_grp.cnt].y     = y_at[n_grp.cnt];
                n_grp.rec[n_grp.cnt].last  = 1'b1;
                n_grp.cnt = n_grp.cnt + 2'd1;
            end
        end

        n_pos = q;
        n_y   = y_at[n_grp.cnt];

        // restart for the next text
        if (i_last_char) begin
            n_pos  = '0;
            n_cls  = '0;
            n_wb   = '0;
            n_acc  = 8'd0;
            n_hw   = 1'b0;
            n_skip = 1'b1;
            n_acr  = 1'b0;
            n_y    = i_cfg.box_y;
        end
    end

    // Push a group only when the character closed a line
    assign o_push.valid = i_accept && (n_grp.cnt != 2'd0);
    assign o_push.grp   = n_grp;

    // Advance line state on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_cls  <= '0;
            r_wb   <= '0;
            r_acc  <= 8'd0;
            r_hw   <= 1'b0;
            r_skip <= 1'b1;
            r_acr  <= 1'b0;
            r_y    <= 16'd0;
        end else begin
            if (i_accept) begin
                r_pos  <= n_pos;
                r_cls  <= n_cls;
                r_wb   <= n_wb;
                r_acc  <= n_acc;
                r_hw   <= n_hw;
                r_skip <= n_skip;
                r_acr  <= n_acr;
                r_y    <= n_y;
            end
            // take the new top coordinate straight from the write word
            if (i_box_y_load) begin
                r_y <= i_box_y_data;
            end
        end
    end

endmodule

[rtl/fww_queue.sv]
// Short queue of line groups between the front and back end.
// Depends on fww_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_width_word_wrap_assert.svh"

module fww_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fww_pkg::t_group_msg i_push,
    input  logic                i_pop,
    output fww_pkg::t_group_msg o_head,
    output logic                o_full
);
    import fww_pkg::*;

    localparam int         PW    = $clog2(QUEUE_DEPTH);
    localparam logic [PW:0] DEPTH = (PW + 1)'(QUEUE_DEPTH);

    t_group        r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;
    logic          pop_ok;

    assign pop_ok       = i_pop && (r_count != '0);
    assign o_full       = (r_count == DEPTH);
    assign o_head.valid = (r_count != '0);
    assign o_head.grp   = r_mem[r_rd];

    // Store pushed groups
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.grp;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop_ok) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push.valid && !pop_ok) begin
                r_count <= r_count + (PW + 1)'(1);
            end else if (!i_push.valid && pop_ok) begin
                r_count <= r_count - (PW + 1)'(1);
            end
        end
    end

    `FWW_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH, "queue overfilled")
    `FWW_ASSERT_IMP(a_push_nonempty, i_clk, i_rst_n, i_push.valid, i_push.grp.cnt != 2'd0 && !o_full, "bad push")
    `FWW_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push.valid && !pop_ok, r_count == $past(r_count) + (PW + 1)'(1), "count did not rise")

endmodule

[rtl/fww_back.sv]
// Back end: unpacks line groups, aligns each line, holds the output word.
// Depends on fww_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_width_word_wrap_assert.svh"

module fww_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fww_pkg::t_group_msg i_head,
    output logic                o_pop,
    input  fww_pkg::t_cfg       i_cfg,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [15:0]         o_line_start,
    output logic [7:0]          o_line_length,
    output logic signed [15:0]  o_line_x,
    output logic signed [15:0]  o_line_y,
    output logic                o_last_line
);
    import fww_pkg::*;

    // Unpack stage
    logic        r_av;
    t_group      r_grp;
    logic [1:0]  r_idx;
    // Width stage
    logic        r_bv;
    logic [15:0] r_b_start, r_b_y, r_b_w;
    logic [7:0]  r_b_len;
    logic        r_b_last;
    // Output stage
    logic        r_ov;
    logic [15:0] r_o_start, r_o_x, r_o_y;
    logic [7:0]  r_o_len;
    logic        r_o_last;

    logic        out_free, b_free, a_adv, a_last, pop;
    t_line_rec   cur;
    logic [15:0] diff, x_off;

    assign out_free = !r_ov || !i_out_stall;
    assign b_free   = !r_bv || out_free;
    assign a_adv    = r_av && b_free;
    assign a_last   = (r_idx == r_grp.cnt - 2'd1);
    assign pop      = i_head.valid && (!r_av || (a_adv && a_last));
    assign o_pop    = pop;
    assign cur      = r_grp.rec[r_idx];

    // Take the next group or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av  <= 1'b0;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_av  <= 1'b1;
            r_idx <= 2'd0;
        end else if (a_adv) begin
            if (a_last) begin
                r_av <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_grp <= i_head.grp;
        end
    end

    // Register the pixel width of the line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (b_free) begin
            r_bv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_free) begin
            r_b_start <= cur.start;
            r_b_len   <= cur.len;
            r_b_y     <= cur.y;
            r_b_last  <= cur.last;
            r_b_w     <= {8'd0, cur.len} * {8'd0, i_cfg.char_width};
        end
    end

    // Offset from the left edge; left when the line is wider than the box
    always_comb begin
        diff  = i_cfg.box_width - r_b_w;
        x_off = 16'd0;
        if (r_b_w <= i_cfg.box_width) begin
            case (t_align'(i_cfg.align_mode))
                ALIGN_CENTER: x_off = {1'b0, diff[15:1]};
                ALIGN_RIGHT:  x_off = diff;
                default:      x_off = 16'd0;
            endcase
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= r_bv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o_start <= r_b_start;
            r_o_len   <= r_b_len;
            r_o_x     <= i_cfg.box_x + x_off;
            r_o_y     <= r_b_y;
            r_o_last  <= r_b_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_line_start  = r_o_start;
    assign o_line_length = r_o_len;
    assign o_line_x      = r_o_x;
    assign o_line_y      = r_o_y;
    assign o_last_line   = r_o_last;

    `FWW_ASSERT_IMP(a_idx_in_group, i_clk, i_rst_n, r_av, r_idx < r_grp.cnt, "index past group")
    `FWW_ASSERT_NXT(a_width_hold, i_clk, i_rst_n, r_bv && !out_free, r_bv && $stable(r_b_w), "width stage lost")
    `FWW_ASSERT_NXT(a_pop_loads, i_clk, i_rst_n, pop, r_av && r_idx == 2'd0, "group not loaded")

endmodule

[rtl/fixed_width_word_wrap.sv]
// Top level of the fixed-width word wrap block: config registers and wiring.
// Depends on fww_pkg, fww_front, fww_queue and fww_back.
//
//   channel  direction  handshake                   word
//   in       sink       i_in_valid / o_in_stall     i_char_code, i_last_char
//   out      source     o_out_valid / i_out_stall   o_line_start .. o_last_line
//   cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One character is taken per cycle while o_in_stall is low; the front end
// settles it in that cycle. Lines leave one per cycle while i_out_stall is low;
// a character's first line passes the queue, unpack, width and output stages.
// A character that closes two or three lines holds the back end while they
// leave; a four-entry group queue absorbs that, and o_in_stall rises when full.
// Synchronous active-low reset loads the register defaults and a fresh text.
`timescale 1ns / 1ps

module fixed_width_word_wrap #(
    parameter int MAX_LINE_CHARS = 255,
    parameter int OFFSET_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_line_start,
    output logic [7:0]         o_line_length,
    output logic signed [15:0] o_line_x,
    output logic signed [15:0] o_line_y,
    output logic               o_last_line,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import fww_pkg::*;

    localparam int OFS_CAP = (OFFSET_BITS >= 9) ? 255 : (2 ** OFFSET_BITS) - 2;
    localparam int LIM_CAP = (MAX_LINE_CHARS < OFS_CAP) ? MAX_LINE_CHARS : OFS_CAP;

    t_cfg       r_cfg;
    logic       cfg_wr, box_y_load, in_accept, pop, full;
    t_group_msg push, head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign box_y_load  = cfg_wr && (t_reg_idx'(i_cfg_index) == REG_BOX_Y);
    assign o_in_stall  = full;
    assign in_accept   = i_in_valid && !full;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chars_per_line <= 8'd40;
            r_cfg.char_width     <= 8'd8;
            r_cfg.char_height    <= 8'd8;
            r_cfg.box_x          <= 16'd0;
            r_cfg.box_y          <= 16'd0;
            r_cfg.box_width      <= 16'd320;
            r_cfg.align_mode     <= ALIGN_LEFT;
        end else if (cfg_wr) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CHARS_PER_LINE: r_cfg.chars_per_line <= i_cfg_data[7:0];
                REG_CHAR_WIDTH:     r_cfg.char_width     <= i_cfg_data[7:0];
                REG_CHAR_HEIGHT:    r_cfg.char_height    <= i_cfg_data[7:0];
                REG_BOX_X:          r_cfg.box_x          <= i_cfg_data;
                REG_BOX_Y:          r_cfg.box_y          <= i_cfg_data;
                REG_BOX_WIDTH:      r_cfg.box_width      <= i_cfg_data;
                REG_ALIGN_MODE:     r_cfg.align_mode     <= i_cfg_data[1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    fww_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LIM_CAP     (LIM_CAP)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_char_code  (i_char_code),
        .i_last_char  (i_last_char),
        .i_cfg        (r_cfg),
        .i_box_y_load (box_y_load),
        .i_box_y_data (i_cfg_data),
        .o_push       (push)
    );

    fww_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    fww_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_cfg         (r_cfg),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_line_start  (o_line_start),
        .o_line_length (o_line_length),
        .o_line_x      (o_line_x),
        .o_line_y      (o_line_y),
        .o_last_line   (o_last_line)
    );

endmodule
